// File: rtl/utf8n_pkg.sv
package utf8n_pkg;

	localparam int unsigned AccW = 21;

	localparam logic [AccW-1:0] CP_ASCII_MAX = 21'h00007F;
	localparam logic [AccW-1:0] CP_TWO_MIN   = 21'h000080;
	localparam logic [AccW-1:0] CP_THREE_MIN = 21'h000800;
	localparam logic [AccW-1:0] CP_FOUR_MIN  = 21'h010000;
	localparam logic [AccW-1:0] CP_SURR_LO   = 21'h00D800;
	localparam logic [AccW-1:0] CP_SURR_HI   = 21'h00DFFF;
	localparam logic [AccW-1:0] CP_MAX       = 21'h10FFFF;
	localparam logic [AccW-1:0] CP_COMB_LO   = 21'h000300;
	localparam logic [AccW-1:0] CP_COMB_HI   = 21'h00036F;
	localparam logic [AccW-1:0] CP_CYR_IO    = 21'h000401;
	localparam logic [AccW-1:0] CP_CYR_IO_LC = 21'h000451;
	localparam logic [AccW-1:0] CP_CYR_IE_LC = 21'h000435;
	localparam logic [AccW-1:0] CP_FOLD_OFS  = 21'h000020;

	localparam logic [7:0] SPACE_BYTE = 8'h20;

	localparam logic [1:0] SEQ_NONE  = 2'd0;
	localparam logic [1:0] SEQ_TWO   = 2'd1;
	localparam logic [1:0] SEQ_THREE = 2'd2;
	localparam logic [1:0] SEQ_FOUR  = 2'd3;

	typedef struct packed {
		logic [AccW-1:0] code_acc;
		logic [1:0]      cont_left;
		logic [1:0]      seq_len;
		logic            space_pend;
		logic            started;
	} state_t;

	// results caused by one input byte
	typedef struct packed {
		logic            push;
		logic            data;
		logic            last;
		logic [1:0]      cnt;
		logic [2:0][7:0] bytes;
	} bundle_t;

	function automatic logic [AccW-1:0] fold_cp(input logic [AccW-1:0] cp);
		logic [AccW-1:0] r;
		r = cp;
		if (cp >= 21'h000041 && cp <= 21'h00005A) begin
			r = cp + CP_FOLD_OFS;
		end else if (cp >= 21'h000410 && cp <= 21'h00042F) begin
			r = cp + CP_FOLD_OFS;
		end else if (cp == CP_CYR_IO || cp == CP_CYR_IO_LC) begin
			r = CP_CYR_IE_LC;
		end
		return r;
	endfunction

	function automatic logic is_word(input logic [AccW-1:0] cp);
		return (cp >= 21'h000061 && cp <= 21'h00007A)
			|| (cp >= 21'h000030 && cp <= 21'h000039)
			|| (cp >= 21'h000430 && cp <= 21'h00044F);
	endfunction

	// overlong, surrogate or beyond the code space
	function automatic logic seq_bad(input logic [1:0] len, input logic [AccW-1:0] cp);
		return (len == SEQ_TWO && cp < CP_TWO_MIN)
			|| (len == SEQ_THREE && cp < CP_THREE_MIN)
			|| (len == SEQ_FOUR && cp < CP_FOUR_MIN)
			|| (cp >= CP_SURR_LO && cp <= CP_SURR_HI)
			|| (cp > CP_MAX);
	endfunction

endpackage

// File: rtl/utf8n_in_if.sv
interface utf8n_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       text_last;

	modport source (output valid, output in_byte, output text_last, input ready);
	modport sink (input valid, input in_byte, input text_last, output ready);
endinterface

// File: rtl/utf8n_out_if.sv
interface utf8n_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       run_last;
	logic       text_end;

	modport source (output valid, output out_byte, output byte_valid, output run_last,
		output text_end, input ready);
	modport sink (input valid, input out_byte, input byte_valid, input run_last,
		input text_end, output ready);
endinterface

// File: rtl/utf8n_step.sv
module utf8n_step import utf8n_pkg::*; (
	input  state_t     cur,
	input  logic [7:0] in_byte,
	input  logic       text_last,
	output state_t     nxt,
	output bundle_t    res
);

	logic            is_cont, open, sep_a, lead_en, fin, fin_bad;
	logic            ld_ascii, ld_two, ld_three, ld_four, bad_lead;
	logic            cp_en, comb_mark, word, emit, sep_any, space, two;
	logic [AccW-1:0] cont_acc, cp_raw, cp;
	logic [7:0]      w0, w1;
	logic [1:0]      n;

	always_comb begin
		is_cont  = (in_byte[7:6] == 2'b10);
		open     = (cur.cont_left != 2'd0);
		sep_a    = open & ~is_cont;
		// a byte that breaks a sequence is decoded again as a lead
		lead_en  = ~open | ~is_cont;
		cont_acc = {cur.code_acc[AccW-7:0], in_byte[5:0]};
		fin      = open & is_cont & (cur.cont_left == 2'd1);
		fin_bad  = seq_bad(cur.seq_len, cont_acc);

		ld_ascii = ~in_byte[7];
		ld_two   = (in_byte[7:5] == 3'b110);
		ld_three = (in_byte[7:4] == 4'b1110);
		ld_four  = (in_byte[7:3] == 5'b11110);
		bad_lead = lead_en & ~(ld_ascii | ld_two | ld_three | ld_four);

		cp_en     = (lead_en & ld_ascii) | (fin & ~fin_bad);
		cp_raw    = lead_en ? {13'd0, in_byte} : cont_acc;
		cp        = fold_cp(cp_raw);
		comb_mark = (cp >= CP_COMB_LO) && (cp <= CP_COMB_HI);
		word      = is_word(cp);
		emit      = cp_en & ~comb_mark & word;
		sep_any   = sep_a | bad_lead | (fin & fin_bad) | (cp_en & ~comb_mark & ~word);
		space     = emit & cur.started & (cur.space_pend | sep_a);
		two       = (cp > CP_ASCII_MAX);

		if (two) begin
			w0 = {3'b110, cp[10:6]};
			w1 = {2'b10, cp[5:0]};
		end else begin
			w0 = cp[7:0];
			w1 = 8'h00;
		end
		n = {1'b0, space} + (two ? 2'd2 : 2'd1);

		nxt.space_pend = emit ? 1'b0 : (cur.space_pend | (sep_any & cur.started));
		nxt.started    = cur.started | emit;
		if (lead_en) begin
			priority if (ld_two) begin
				nxt.code_acc  = {16'd0, in_byte[4:0]};
				nxt.cont_left = 2'd1;
				nxt.seq_len   = SEQ_TWO;
			end else if (ld_three) begin
				nxt.code_acc  = {17'd0, in_byte[3:0]};
				nxt.cont_left = 2'd2;
				nxt.seq_len   = SEQ_THREE;
			end else if (ld_four) begin
				nxt.code_acc  = {18'd0, in_byte[2:0]};
				nxt.cont_left = 2'd3;
				nxt.seq_len   = SEQ_FOUR;
			end else begin
				nxt.code_acc  = '0;
				nxt.cont_left = 2'd0;
				nxt.seq_len   = SEQ_NONE;
			end
		end else if (fin) begin
			nxt.code_acc  = '0;
			nxt.cont_left = 2'd0;
			nxt.seq_len   = SEQ_NONE;
		end else begin
			nxt.code_acc  = cont_acc;
			nxt.cont_left = cur.cont_left - 2'd1;
			nxt.seq_len   = cur.seq_len;
		end
		if (text_last) begin
			nxt = '0;
		end

		res.push = emit | text_last;
		res.data = emit;
		res.last = text_last;
		res.cnt  = emit ? n : 2'd1;
		if (!emit) begin
			res.bytes = '0;
		end else if (space) begin
			res.bytes = {w1, w0, SPACE_BYTE};
		end else begin
			res.bytes = {8'h00, w1, w0};
		end
	end

endmodule

// File: rtl/utf8_search_text_normalizer.sv
// UTF-8 search-text normalizer.
// text_in carries one raw text byte per transfer, text_last marking the final
// byte of a text. text_out carries the normalized bytes one per transfer:
// lowercased Latin/Cyrillic word characters re-encoded as UTF-8, single spaces
// between words. run_last flags the last result caused by an input byte and
// text_end the last result of a text; a final byte that yields no data gives
// one bare end marker (byte_valid low).
// Each input byte is decoded in the cycle it is taken; its results are held in
// a one-bundle buffer and then shifted out of the output register. A byte is
// taken every cycle while text_in.ready is high; a byte with several results
// holds the output register until all are out, and as output can outgrow
// input, the input may then stall. Reset clears the decoder state and the
// valid flags of both result registers (their data is not reset); nothing
// needs sweeping. When the receiver stalls, the output holds its byte and the
// buffer fills, after which text_in.ready drops until the output drains.
module utf8_search_text_normalizer import utf8n_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	utf8n_in_if.sink     text_in,
	utf8n_out_if.source  text_out
);

	state_t     st_q, st_next;
	bundle_t    step_res;
	bundle_t    buf_s1, ser_s2;
	logic       buf_v_q, ser_v_q;
	logic [1:0] idx_q;
	logic       in_fire, ser_done, ser_load, run_last;

	utf8n_step u_step (
		.cur       (st_q),
		.in_byte   (text_in.in_byte),
		.text_last (text_in.text_last),
		.nxt       (st_next),
		.res       (step_res)
	);

	assign run_last  = (idx_q == 2'(ser_s2.cnt - 2'd1));
	assign ser_done  = ser_v_q & text_out.ready & run_last;
	assign ser_load  = buf_v_q & (~ser_v_q | ser_done);
	assign text_in.ready = ~buf_v_q | ~ser_v_q | ser_done;
	assign in_fire   = text_in.valid & text_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= '0;
			buf_v_q <= 1'b0;
			ser_v_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (in_fire) begin
				st_q <= st_next;
			end
			if (in_fire && step_res.push) begin
				buf_v_q <= 1'b1;
			end else if (ser_load) begin
				buf_v_q <= 1'b0;
			end
			if (ser_load) begin
				ser_v_q <= 1'b1;
				idx_q   <= 2'd0;
			end else if (ser_done) begin
				ser_v_q <= 1'b0;
			end else if (ser_v_q && text_out.ready) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && step_res.push) begin
			buf_s1 <= step_res;
		end
		if (ser_load) begin
			ser_s2 <= buf_s1;
		end
	end

	always_comb begin
		unique case (idx_q)
			2'd0:    text_out.out_byte = ser_s2.bytes[0];
			2'd1:    text_out.out_byte = ser_s2.bytes[1];
			default: text_out.out_byte = ser_s2.bytes[2];
		endcase
	end

	assign text_out.valid      = ser_v_q;
	assign text_out.byte_valid = ser_s2.data;
	assign text_out.run_last   = run_last;
	assign text_out.text_end   = run_last & ser_s2.last;

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ser_v_q |-> (idx_q < ser_s2.cnt))
		else $error("result index past bundle size");

	a_marker_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(ser_v_q && !ser_s2.data) |-> (ser_s2.cnt == 2'd1 && ser_s2.last))
		else $error("end marker bundle malformed");

	a_clear_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && text_in.text_last) |=> (st_q == '0))
		else $error("decoder state not cleared after text end");

	a_seq_count: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.cont_left <= st_q.seq_len) && ((st_q.seq_len == SEQ_NONE) == (st_q.cont_left == 2'd0)))
		else $error("continuation count inconsistent with sequence length");

endmodule
